// ----- rtl/wbrp_pkg.sv -----
// Shared types and constants of the write batch record parser.
// No dependencies; every module of the parser imports this package.
`default_nettype none

package wbrp_pkg;

   localparam logic [7:0] TAG_PUT      = 8'd1;
   localparam logic [7:0] TAG_DELETE   = 8'd0;
   localparam logic       KIND_PUT     = 1'b0;
   localparam logic       KIND_DELETE  = 1'b1;
   localparam logic       PART_KEY     = 1'b0;
   localparam logic       PART_VALUE   = 1'b1;
   localparam logic [3:0] HEADER_BYTES = 4'd12;
   localparam logic [3:0] SEQ_BYTES    = 4'd8;
   localparam logic [3:0] KEY_LEN_MAX  = 4'd5;
   localparam logic [3:0] VAL_LEN_MAX  = 4'd10;

   // One raw batch byte with its end marker.
   typedef struct packed {
      logic       last;
      logic [7:0] data;
   } item_type;

   // One parsed result.
   typedef struct packed {
      logic        kind;
      logic        part;
      logic [7:0]  data;
      logic        has_payload;
      logic        end_of_part;
      logic        end_of_record;
      logic [63:0] sequence_num;
      logic        status;
   } res_type;

endpackage

`default_nettype wire

// ----- rtl/wbrp_in_reg.sv -----
// Input register of the write batch record parser.
// Depends on wbrp_pkg for the item type.
`default_nettype none

module wbrp_in_reg (
   input  wire                clock,
   input  wire                reset,
   input  wire                in_valid,
   output logic               in_ready,
   input  wbrp_pkg::item_type in_item,
   input  wire                advance,
   output logic               hold_valid,
   output wbrp_pkg::item_type hold_item
);
   import wbrp_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // Take a new transaction whenever the held one is empty or moves on.
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

`default_nettype wire

// ----- rtl/wbrp_parse.sv -----
// Parser state and per-byte decode of the write batch record parser.
// Depends on wbrp_pkg for types, tag codes and header/varint limits.
`default_nettype none

module wbrp_parse (
   input  wire                clock,
   input  wire                reset,
   input  wire                advance,
   input  wbrp_pkg::item_type item,
   output logic               res_valid,
   output wbrp_pkg::res_type  res
);
   import wbrp_pkg::*;

   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_TAG     = 3'd1;
   localparam logic [2:0] PH_KEYLEN  = 3'd2;
   localparam logic [2:0] PH_KEYDATA = 3'd3;
   localparam logic [2:0] PH_VALLEN  = 3'd4;
   localparam logic [2:0] PH_VALDATA = 3'd5;

   logic [2:0]  phase_ff,  phase_in;
   logic [3:0]  hdr_idx_ff, hdr_idx_in;
   logic [63:0] seq_ff,    seq_in;
   logic [63:0] len_acc_ff, len_acc_in;
   logic [3:0]  vcnt_ff,   vcnt_in;
   logic [63:0] remain_ff, remain_in;
   logic        kind_ff,   kind_in;
   logic        drop_ff,   drop_in;

   logic        err;
   logic        close;
   logic        close_key;
   logic [7:0]  close_data;
   logic        close_has;
   logic        rec_end;
   logic        is_key;
   logic [3:0]  limit;
   logic [6:0]  shamt;
   logic [63:0] len_new;
   logic [63:0] len_fin;
   logic [3:0]  vcnt_inc;
   logic [63:0] rem_dec;
   logic [63:0] seq_base;
   logic [3:0]  hdr_inc;
   res_type     err_res;

   always_comb begin
      err_res        = '0;
      err_res.status = 1'b1;
   end

   always_comb begin
      phase_in   = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      seq_in     = seq_ff;
      len_acc_in = len_acc_ff;
      vcnt_in    = vcnt_ff;
      remain_in  = remain_ff;
      kind_in    = kind_ff;
      drop_in    = drop_ff;
      res_valid  = 1'b0;
      res        = '0;
      err        = 1'b0;
      close      = 1'b0;
      close_key  = 1'b0;
      close_data = 8'd0;
      close_has  = 1'b0;
      rec_end    = 1'b0;
      is_key     = (phase_ff == PH_KEYLEN) || (phase_ff == PH_KEYDATA);
      limit      = is_key ? KEY_LEN_MAX : VAL_LEN_MAX;
      // 7 * count without a multiplier
      shamt      = {vcnt_ff, 3'b000} - {3'b000, vcnt_ff};
      len_new    = len_acc_ff | ({57'd0, item.data[6:0]} << shamt);
      len_fin    = is_key ? {32'd0, len_new[31:0]} : len_new;
      vcnt_inc   = vcnt_ff + 4'd1;
      rem_dec    = remain_ff - 64'd1;
      seq_base   = (hdr_idx_ff == 4'd0) ? 64'd0 : seq_ff;
      hdr_inc    = hdr_idx_ff + 4'd1;

      if (!drop_ff) begin
         case (phase_ff)
            PH_TAG: begin
               if (item.data == TAG_PUT) begin
                  kind_in  = KIND_PUT;
                  phase_in = PH_KEYLEN;
               end else if (item.data == TAG_DELETE) begin
                  kind_in  = KIND_DELETE;
                  phase_in = PH_KEYLEN;
               end else begin
                  err = 1'b1;
               end
               len_acc_in = 64'd0;
               vcnt_in    = 4'd0;
            end
            PH_KEYLEN, PH_VALLEN: begin
               if (item.data[7]) begin
                  len_acc_in = len_new;
                  vcnt_in    = vcnt_inc;
                  if (vcnt_inc >= limit) begin
                     err = 1'b1;
                  end
               end else begin
                  len_acc_in = 64'd0;
                  vcnt_in    = 4'd0;
                  if (len_fin == 64'd0) begin
                     close     = 1'b1;
                     close_key = is_key;
                  end else begin
                     remain_in = len_fin;
                     phase_in  = is_key ? PH_KEYDATA : PH_VALDATA;
                  end
               end
            end
            PH_KEYDATA, PH_VALDATA: begin
               remain_in = rem_dec;
               if (rem_dec == 64'd0) begin
                  close      = 1'b1;
                  close_key  = is_key;
                  close_data = item.data;
                  close_has  = 1'b1;
               end else begin
                  res_valid        = 1'b1;
                  res.kind         = kind_ff;
                  res.part         = is_key ? PART_KEY : PART_VALUE;
                  res.data         = item.data;
                  res.has_payload  = 1'b1;
                  res.sequence_num = seq_ff;
               end
            end
            default: begin
               // header: 8 sequence bytes little-endian, then 4 skipped count bytes
               seq_in = seq_base;
               if (hdr_idx_ff < SEQ_BYTES) begin
                  seq_in = seq_base | ({56'd0, item.data} << {hdr_idx_ff[2:0], 3'b000});
               end
               if (hdr_inc >= HEADER_BYTES) begin
                  hdr_idx_in = 4'd0;
                  phase_in   = PH_TAG;
               end else begin
                  hdr_idx_in = hdr_inc;
                  phase_in   = PH_HEADER;
               end
            end
         endcase

         if (close) begin
            rec_end           = !(close_key && (kind_ff == KIND_PUT));
            res_valid         = 1'b1;
            res.kind          = kind_ff;
            res.part          = close_key ? PART_KEY : PART_VALUE;
            res.data          = close_data;
            res.has_payload   = close_has;
            res.end_of_part   = 1'b1;
            res.end_of_record = rec_end;
            res.sequence_num  = seq_ff;
            if (rec_end) begin
               seq_in   = seq_ff + 64'd1;
               phase_in = PH_TAG;
            end else begin
               phase_in   = PH_VALLEN;
               len_acc_in = 64'd0;
               vcnt_in    = 4'd0;
            end
         end

         if (err) begin
            res_valid = 1'b1;
            res       = err_res;
            drop_in   = 1'b1;
         end

         // batch cut short anywhere but a record boundary
         if (item.last && !err && (phase_in != PH_TAG)) begin
            res_valid = 1'b1;
            res       = err_res;
         end
      end

      if (item.last) begin
         phase_in   = PH_HEADER;
         hdr_idx_in = 4'd0;
         len_acc_in = 64'd0;
         vcnt_in    = 4'd0;
         remain_in  = 64'd0;
         drop_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_idx_ff <= 4'd0;
         seq_ff     <= 64'd0;
         len_acc_ff <= 64'd0;
         vcnt_ff    <= 4'd0;
         remain_ff  <= 64'd0;
         kind_ff    <= KIND_PUT;
         drop_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         seq_ff     <= seq_in;
         len_acc_ff <= len_acc_in;
         vcnt_ff    <= vcnt_in;
         remain_ff  <= remain_in;
         kind_ff    <= kind_in;
         drop_ff    <= drop_in;
      end
   end

   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> !res_valid)
      else $error("result produced while dropping");

   a_data_remaining: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_KEYDATA) || (phase_ff == PH_VALDATA)) && !drop_ff
         |-> remain_ff != 64'd0)
      else $error("data phase with no bytes remaining");

   a_varint_bound: assert property (@(posedge clock) disable iff (reset)
      vcnt_ff <= VAL_LEN_MAX)
      else $error("varint byte count out of range");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status |-> !res.has_payload && res.sequence_num == 64'd0)
      else $error("error result carries payload");

endmodule

`default_nettype wire

// ----- rtl/wbrp_out_reg.sv -----
// Result register of the write batch record parser.
// Depends on wbrp_pkg for the result type.
`default_nettype none

module wbrp_out_reg (
   input  wire               clock,
   input  wire               reset,
   input  wire               advance,
   input  wire               res_valid,
   input  wbrp_pkg::res_type res,
   output logic              out_valid,
   input  wire               out_ready,
   output wbrp_pkg::res_type out_res
);
   import wbrp_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   res_type res_ff;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = res_valid;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         res_ff <= res;
      end
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;

endmodule

`default_nettype wire

// ----- rtl/write_batch_record_parser.sv -----
// Top level of the write batch record parser: input register, parse stage, result register.
// Depends on wbrp_pkg, wbrp_in_reg, wbrp_parse and wbrp_out_reg.
//
// Takes a write batch one byte per transaction (tlast on the final byte) and
// returns one transaction per key or value byte, one per empty part, and a single
// corruption transaction on a bad tag, an overlong length or a truncated batch,
// after which the rest of that batch is dropped. Sustained rate is one byte per
// clock with no gaps while the result side takes every result. A byte sits in the
// input register while the parse stage decodes it, and its result then loads into
// the result register, which offers it; a full result register that is not taken
// holds the byte in the input register. The input side can accept a byte while
// a result waits, and stalls only when the input register is full and the result
// register holds a result that is not being taken.
// No startup pass is needed after reset.
`default_nettype none

module write_batch_record_parser (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] batch_byte
   input  wire         req_tlast,   // end_of_batch
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,   // [7:0] payload_byte, [71:8] record_sequence
   output logic [4:0]  rsp_tuser,   // [0] record_kind, [1] part, [2] has_payload,
                                    // [3] end_of_part, [4] status
   output logic        rsp_tlast    // end_of_record
);
   import wbrp_pkg::*;

   item_type req_item;
   item_type hold_item;
   logic     hold_valid;
   logic     advance;
   logic     res_valid;
   res_type  res;
   res_type  out_res;

   assign req_item.data = req_tdata;
   assign req_item.last = req_tlast;

   // Advance a byte when the result slot is free or draining this cycle.
   assign advance = hold_valid && (!rsp_tvalid || rsp_tready);

   wbrp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   wbrp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (hold_item),
      .res_valid (res_valid),
      .res       (res)
   );

   wbrp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .res_valid (res_valid),
      .res       (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata = {out_res.sequence_num, out_res.data};
   assign rsp_tuser = {out_res.status, out_res.end_of_part, out_res.has_payload,
                       out_res.part, out_res.kind};
   assign rsp_tlast = out_res.end_of_record;

endmodule

`default_nettype wire
